>>> rtl/core/ikchm_pkg.sv
// shared constants for the chained hash map
package ikchm_pkg;
    localparam logic [1:0] CMD_PUT     = 2'd0;
    localparam logic [1:0] CMD_GET     = 2'd1;
    localparam logic [1:0] CMD_REMOVE  = 2'd2;
    localparam logic [1:0] CMD_REPLACE = 2'd3;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;
    localparam int BCFG_W  = 9;
endpackage

>>> rtl/core/ikchm_mod.sv
// serial remainder unit: key modulo bucket count, one quotient bit per cycle
module ikchm_mod #(
    parameter int BUCKET_W = 9
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ikchm_pkg::KEY_W-1:0]  i_key,
    input  logic [BUCKET_W-1:0]          i_mod,
    output logic                         o_done,
    output logic [BUCKET_W-1:0]          o_rem
);
    import ikchm_pkg::*;

    logic [KEY_W-1:0]    r_key;
    logic [BUCKET_W:0]   r_rem;
    logic [5:0]          r_cnt;
    logic                r_busy;
    logic [BUCKET_W+1:0] w_trial;
    logic [BUCKET_W+1:0] w_diff;

    assign w_trial = {r_rem, r_key[KEY_W-1]};
    assign w_diff  = w_trial - {2'b00, i_mod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_key  <= i_key;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_key <= {r_key[KEY_W-2:0], 1'b0};
                if (!w_diff[BUCKET_W+1]) r_rem <= w_diff[BUCKET_W:0];
                else r_rem <= w_trial[BUCKET_W:0];
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(KEY_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_rem = BUCKET_W'(r_rem);
endmodule

>>> rtl/core/int_key_chained_hash_map.sv
// top level: chained hash map over a slot pool in synchronous memories
// channel | direction | handshake       | payload
// in      | in        | i_valid/o_stall | i_cmd i_key i_value_in
// out     | out       | o_valid/i_stall | o_hit o_full_res o_value_out o_entry_count
// cfg     | in        | i_cfg_we        | i_cfg_data (bucket_count)
// from its transfer to the result an item passes through a serial remainder, a head read,
// a key read and compare per chain entry visited (the walk stops at the compare that finds
// the key), then a write-back, and for a remove an extra write that links the freed slot
// after reset every slot of the link memory is written in turn to form the free list,
// and no item is accepted during this sweep
// the result waits in an output register; the next item is taken once it is transferred
module int_key_chained_hash_map #(
    parameter int BUCKETS    = 256,
    parameter int POOL_SLOTS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_cmd,
    input  logic signed [31:0]              i_key,
    input  logic [31:0]                     i_value_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_hit,
    output logic                            o_full_res,
    output logic [31:0]                     o_value_out,
    output logic [ikchm_pkg::COUNT_W-1:0]   o_entry_count,
    input  logic                            i_cfg_we,
    input  logic [ikchm_pkg::BCFG_W-1:0]    i_cfg_data
);
    import ikchm_pkg::*;

    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SW  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int BMW = $clog2(BUCKETS + 1);
    localparam int CW  = $clog2(POOL_SLOTS + 1);
    localparam int SCW = SW + 1;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_HEADW = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_RDW   = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_ACT   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_FREE  = 4'd10;

    // memories
    logic [KEY_W-1:0]   m_keys [POOL_SLOTS];
    logic [VALUE_W-1:0] m_vals [POOL_SLOTS];
    logic [SW:0]        m_link [POOL_SLOTS];
    logic [SW:0]        m_head [BUCKETS];
    logic [BUCKETS-1:0] r_hvalid;

    logic [3:0]        r_state;
    logic [BCFG_W-1:0] r_bcfg;
    logic [1:0]        r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [VALUE_W-1:0] r_val;
    logic [BW-1:0]     r_bucket;
    logic [SW-1:0]     r_cur;
    logic              r_cur_ok;
    logic [SW-1:0]     r_prev;
    logic              r_has_prev;
    logic [SCW-1:0]    r_steps;
    logic [SW:0]       r_free;
    logic [CW-1:0]     r_count;
    logic [SW-1:0]     r_init;
    logic              r_found;

    logic [KEY_W-1:0]   r_rkey;
    logic [VALUE_W-1:0] r_rval;
    logic [SW:0]        r_rlink;
    logic [SW:0]        r_rhead;
    logic [SW:0]        r_free_next;
    logic [SW:0]        r_free_old;

    logic [BW-1:0]      w_mod;
    logic               w_mod_done;
    logic [BW-1:0]      w_rem;
    logic               w_start;
    logic               w_acc;
    logic               w_ins;

    logic               r_out_v;
    logic               r_hit;
    logic               r_full;
    logic [VALUE_W-1:0] r_vout;

    // effective modulus
    always_comb begin
        if (r_bcfg == '0) w_mod = BW'(1);
        else if (32'(r_bcfg) >= 32'(BUCKETS)) w_mod = BW'(BUCKETS - 1);
        else w_mod = BW'(r_bcfg);
    end

    logic            w_full_mod;
    assign w_full_mod = (r_bcfg != '0) && (32'(r_bcfg) >= 32'(BUCKETS));

    logic [BMW-1:0] w_modw;
    assign w_modw = w_full_mod ? BMW'(BUCKETS) : BMW'(w_mod);

    logic [BMW-1:0] w_remw;
    ikchm_mod #(.BUCKET_W(BMW)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_key   (i_key),
        .i_mod   (w_modw),
        .o_done  (w_mod_done),
        .o_rem   (w_remw)
    );
    assign w_rem = BW'(w_remw);

    assign o_stall = (r_state != S_IDLE) || r_out_v;
    assign w_acc   = i_valid && !o_stall;
    assign w_start = (r_state == S_IDLE) && w_acc;
    assign w_ins   = (r_cmd == CMD_PUT) || (r_cmd == CMD_REPLACE);

    logic w_keyeq;
    assign w_keyeq = (r_rkey == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_init   <= '0;
            r_bcfg   <= BCFG_W'(256);
            r_hvalid <= '0;
            r_free   <= {1'b1, SW'(0)};
            r_count  <= '0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_we) r_bcfg <= i_cfg_data;
            if (r_out_v && !i_stall) r_out_v <= 1'b0;
            case (r_state)
                S_INIT: begin
                    m_link[r_init] <= {(32'(r_init) + 1 < 32'(POOL_SLOTS)),
                                       SW'(32'(r_init) + 1)};
                    r_init <= r_init + SW'(1);
                    if (32'(r_init) == POOL_SLOTS - 1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_cmd   <= i_cmd;
                        r_key   <= i_key;
                        r_val   <= i_value_in;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_bucket <= w_rem;
                        r_state  <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_rhead <= m_head[r_bucket];
                    r_state <= S_HEADW;
                end
                S_HEADW: begin
                    r_cur      <= r_rhead[SW-1:0];
                    r_cur_ok   <= r_hvalid[r_bucket];
                    r_has_prev <= 1'b0;
                    r_prev     <= '0;
                    r_steps    <= '0;
                    r_found    <= 1'b0;
                    r_state    <= S_RD;
                end
                S_RD: begin
                    if (!r_cur_ok || 32'(r_steps) >= POOL_SLOTS) begin
                        r_state <= S_ACT;
                    end else begin
                        r_rkey  <= m_keys[r_cur];
                        r_rval  <= m_vals[r_cur];
                        r_rlink <= m_link[r_cur];
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (w_keyeq) begin
                        r_found <= 1'b1;
                        r_state <= S_ACT;
                    end else begin
                        r_prev     <= r_cur;
                        r_has_prev <= 1'b1;
                        r_cur_ok   <= r_rlink[SW];
                        r_cur      <= r_rlink[SW-1:0];
                        r_steps    <= r_steps + SCW'(1);
                        r_state    <= S_RD;
                    end
                end
                S_ACT: begin
                    r_hit  <= r_found;
                    r_full <= !r_found && w_ins && !r_free[SW];
                    r_vout <= (r_found && r_cmd != CMD_PUT) ? r_rval : '0;
                    if (r_found && r_cmd == CMD_REMOVE) begin
                        if (r_has_prev) m_link[r_prev] <= r_rlink;
                        else begin
                            m_head[r_bucket]   <= r_rlink;
                            r_hvalid[r_bucket] <= r_rlink[SW];
                        end
                        r_free  <= {1'b1, r_cur};
                        r_state <= S_FREE;
                    end else begin
                        if (!r_found && w_ins && r_free[SW]) begin
                            m_keys[r_free[SW-1:0]] <= r_key;
                            m_vals[r_free[SW-1:0]] <= r_val;
                            m_link[r_free[SW-1:0]] <= {r_hvalid[r_bucket],
                                                       r_rhead[SW-1:0]};
                            m_head[r_bucket]       <= {1'b1, r_free[SW-1:0]};
                            r_hvalid[r_bucket]     <= 1'b1;
                            r_count                <= r_count + CW'(1);
                            r_free                 <= r_free_next;
                        end
                        if (r_found && r_cmd == CMD_REPLACE) m_vals[r_cur] <= r_val;
                        r_state <= S_OUT;
                    end
                end
                S_FREE: begin
                    m_link[r_cur] <= r_free_old;
                    if (r_count != '0) r_count <= r_count - CW'(1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_v) begin
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // free list head successor read at the head slot, and saved old head for removes
    always_ff @(posedge i_clk) begin
        r_free_next <= m_link[r_free[SW-1:0]];
        if (r_state == S_ACT) r_free_old <= r_free;
    end

    assign o_valid       = r_out_v;
    assign o_hit         = r_hit;
    assign o_full_res    = r_full;
    assign o_value_out   = r_vout;
    assign o_entry_count = COUNT_W'(r_count);

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !w_acc) else $error("accept while busy");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= POOL_SLOTS) else $error("count overflow");
    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !(r_hit && r_full)) else $error("hit with full");
endmodule
